@@ design/acid_pkg.sv @@
// Shared types, constants and condition table for the conditional divide unit.
package acid_pkg;

  localparam int DATA_W    = 32;
  localparam int NUM_STEPS = DATA_W;
  localparam int LATENCY   = NUM_STEPS + 2;

  localparam logic [31:0] DIV_PATTERN  = 32'h0310_f010;
  localparam logic [3:0]  COND_UNCOND  = 4'hf;
  localparam int          UNSIGNED_BIT = 21;

  localparam logic [1:0] OUTCOME_FAIL   = 2'd0;
  localparam logic [1:0] OUTCOME_PASS   = 2'd1;
  localparam logic [1:0] OUTCOME_UNCOND = 2'd2;

  // Bit number NZCV of each entry says whether that condition passes.
  localparam logic [15:0] COND_MASK [16] = '{
    16'hF0F0, 16'h0F0F, 16'hCCCC, 16'h3333,
    16'hFF00, 16'h00FF, 16'hAAAA, 16'h5555,
    16'h0C0C, 16'hF3F3, 16'hAA55, 16'h55AA,
    16'h0A05, 16'hF5FA, 16'hFFFF, 16'h0000
  };

  typedef struct packed {
    logic [31:0] instruction_word;
    logic [3:0]  nzcv_flags;
    logic [31:0] dividend_value;
    logic [31:0] divisor_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  condition_outcome;
    logic        is_divide;
    logic        write_enable;
    logic [3:0]  dest_register;
    logic [31:0] quotient;
    logic        divide_by_zero;
  } result_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic       is_divide;
    logic       write_enable;
    logic       divide_by_zero;
    logic [3:0] dest;
    logic       negate;
  } ctrl_t;

  typedef struct packed {
    ctrl_t             ctrl;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] dvs;
  } stage_t;

  function automatic logic [1:0] cond_eval(input logic [3:0] cc, input logic [3:0] flags);
    logic [15:0] mask;
    mask = COND_MASK[cc];
    if (cc == COND_UNCOND) begin
      return OUTCOME_UNCOND;
    end
    return mask[flags] ? OUTCOME_PASS : OUTCOME_FAIL;
  endfunction

endpackage

@@ design/arm_conditional_integer_divide_unit.sv @@
// Top level of the pipelined A32 SDIV/UDIV execute unit.
// Fully pipelined: one instruction can start in every cycle (busy is high only during
// reset), and its result appears with a one-cycle done strobe after it passes through
// one decode stage, a chain of 32 radix-2 divide cells (one quotient bit each),
// and one output stage. Results cannot be held off; the receiver must take each
// transaction in the cycle done is high. Results leave in the order instructions came in.
module arm_conditional_integer_divide_unit
  import acid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  logic                 accept;
  logic [NUM_STEPS:0]   chain_valid;
  stage_t               chain [NUM_STEPS+1];

  assign busy   = rst;
  assign accept = start && !busy;

  acid_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .cmd   (cmd),
    .valid (chain_valid[0]),
    .stage (chain[0])
  );

  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_cell
    acid_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .valid_in(chain_valid[i]),
      .stage_in(chain[i]),
      .valid   (chain_valid[i+1]),
      .stage   (chain[i+1])
    );
  end

  acid_finish u_finish (
    .clk     (clk),
    .rst     (rst),
    .valid_in(chain_valid[NUM_STEPS]),
    .stage_in(chain[NUM_STEPS]),
    .done    (done),
    .result  (result)
  );

`ifndef NO_ASSERTIONS
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("result strobe missing at fixed latency");

  a_write_needs_exec: assert property (@(posedge clk) disable iff (rst)
    done && result.write_enable |->
      result.is_divide && (result.condition_outcome != OUTCOME_FAIL) && !result.divide_by_zero)
    else $error("write enable on a non-executed divide");

  a_no_write_zero_quo: assert property (@(posedge clk) disable iff (rst)
    done && !result.write_enable |-> result.quotient == '0)
    else $error("quotient not cleared without write");

  a_dbz_needs_exec: assert property (@(posedge clk) disable iff (rst)
    done && result.divide_by_zero |->
      result.is_divide && (result.condition_outcome != OUTCOME_FAIL))
    else $error("divide by zero flagged on a non-executed divide");
`endif

endmodule

@@ design/acid_decode.sv @@
// Front stage: condition check, pattern match and operand magnitudes.
module acid_decode
  import acid_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  cmd_t   cmd,
  output logic   valid,
  output stage_t stage
);

  logic [1:0]        outcome;
  logic              is_div;
  logic              exec;
  logic              dvs_zero;
  logic              use_signed;
  logic              neg_a;
  logic              neg_b;
  logic [DATA_W-1:0] mag_a;
  logic [DATA_W-1:0] mag_b;
  stage_t            stage_next;

  always_comb begin
    outcome    = cond_eval(cmd.instruction_word[31:28], cmd.nzcv_flags);
    is_div     = (cmd.instruction_word & DIV_PATTERN) == DIV_PATTERN;
    exec       = is_div && (outcome != OUTCOME_FAIL);
    dvs_zero   = cmd.divisor_value == '0;
    use_signed = !cmd.instruction_word[UNSIGNED_BIT];
    neg_a      = use_signed && cmd.dividend_value[DATA_W-1];
    neg_b      = use_signed && cmd.divisor_value[DATA_W-1];
    mag_a      = neg_a ? (DATA_W'(0) - cmd.dividend_value) : cmd.dividend_value;
    mag_b      = neg_b ? (DATA_W'(0) - cmd.divisor_value) : cmd.divisor_value;

    stage_next.ctrl.outcome        = outcome;
    stage_next.ctrl.is_divide      = is_div;
    stage_next.ctrl.write_enable   = exec && !dvs_zero;
    stage_next.ctrl.divide_by_zero = exec && dvs_zero;
    stage_next.ctrl.dest           = cmd.instruction_word[19:16];
    stage_next.ctrl.negate         = neg_a ^ neg_b;
    stage_next.rem                 = '0;
    stage_next.quo                 = mag_a;
    stage_next.dvs                 = mag_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    stage <= stage_next;
  end

endmodule

@@ design/acid_cell.sv @@
// One restoring divide step: shift, trial subtract, register.
module acid_cell
  import acid_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   valid_in,
  input  stage_t stage_in,
  output logic   valid,
  output stage_t stage
);

  logic [DATA_W:0] shifted;
  logic [DATA_W:0] diff;
  logic            fits;
  stage_t          stage_next;

  always_comb begin
    shifted         = {stage_in.rem, stage_in.quo[DATA_W-1]};
    diff            = shifted - {1'b0, stage_in.dvs};
    fits            = !diff[DATA_W];
    stage_next      = stage_in;
    stage_next.rem  = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    stage_next.quo  = {stage_in.quo[DATA_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    stage <= stage_next;
  end

`ifndef NO_ASSERTIONS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    valid && (stage.dvs != '0) |-> stage.rem < stage.dvs)
    else $error("partial remainder not below divisor");
`endif

endmodule

@@ design/acid_finish.sv @@
// Output stage: quotient sign fix, masking and result strobe.
module acid_finish
  import acid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    valid_in,
  input  stage_t  stage_in,
  output logic    done,
  output result_t result
);

  result_t result_next;

  always_comb begin
    result_next.condition_outcome = stage_in.ctrl.outcome;
    result_next.is_divide         = stage_in.ctrl.is_divide;
    result_next.write_enable      = stage_in.ctrl.write_enable;
    result_next.dest_register     = stage_in.ctrl.dest;
    result_next.divide_by_zero    = stage_in.ctrl.divide_by_zero;
    if (!stage_in.ctrl.write_enable) begin
      result_next.quotient = '0;
    end else if (stage_in.ctrl.negate) begin
      result_next.quotient = DATA_W'(0) - stage_in.quo;
    end else begin
      result_next.quotient = stage_in.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule

@@ tb/sv/arm_conditional_integer_divide_unit_test.sv @@
// Self-checking testbench for the pipelined A32 SDIV/UDIV execute unit.
`timescale 1ns / 1ps

module arm_conditional_integer_divide_unit_test;
  import acid_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_CMDS = 1400;
  localparam int MAX_PRINTS  = 50;

  typedef enum logic [3:0] {
    CC_EQ = 4'h0, CC_NE = 4'h1, CC_CS = 4'h2, CC_CC = 4'h3,
    CC_MI = 4'h4, CC_PL = 4'h5, CC_VS = 4'h6, CC_VC = 4'h7,
    CC_HI = 4'h8, CC_LS = 4'h9, CC_GE = 4'hA, CC_LT = 4'hB,
    CC_GT = 4'hC, CC_LE = 4'hD, CC_AL = 4'hE, CC_NV = 4'hF
  } cond_code_t;

  typedef struct {
    cmd_t c;
    bit   drain_first;
    bit   no_idle;
  } pending_cmd_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd = '0;
  logic    busy;
  logic    done;
  result_t result;

  pending_cmd_t pending_cmds[$];
  result_t      expected_results[$];

  int n_sent = 0;
  int n_results = 0;
  int n_errors = 0;
  int cycles_idle = 0;
  int n_exec_signed = 0;
  int n_exec_unsigned = 0;
  int n_div_zero = 0;
  int n_cond_fail = 0;
  int n_not_div = 0;

  arm_conditional_integer_divide_unit i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic cond_passes(logic [3:0] cc, logic [3:0] flags);
    logic n, z, c, v;
    {n, z, c, v} = flags;
    unique case (cc)
      CC_EQ:   return z;
      CC_NE:   return !z;
      CC_CS:   return c;
      CC_CC:   return !c;
      CC_MI:   return n;
      CC_PL:   return !n;
      CC_VS:   return v;
      CC_VC:   return !v;
      CC_HI:   return c && !z;
      CC_LS:   return !c || z;
      CC_GE:   return n == v;
      CC_LT:   return n != v;
      CC_GT:   return !z && (n == v);
      CC_LE:   return z || (n != v);
      default: return 1'b1;
    endcase
  endfunction

  function automatic result_t predict_divide(cmd_t c);
    result_t     r;
    logic [3:0]  cc;
    logic        executes;
    logic [31:0] a, b, mag_a, mag_b, q;
    r = '0;
    cc = c.instruction_word[31:28];
    a = c.dividend_value;
    b = c.divisor_value;
    if (cc == CC_NV) begin
      r.condition_outcome = OUTCOME_UNCOND;
    end else begin
      r.condition_outcome = cond_passes(cc, c.nzcv_flags) ? OUTCOME_PASS : OUTCOME_FAIL;
    end
    r.is_divide = (c.instruction_word & DIV_PATTERN) == DIV_PATTERN;
    r.dest_register = c.instruction_word[19:16];
    executes = r.is_divide && (r.condition_outcome != OUTCOME_FAIL);
    if (executes && b == 32'd0) begin
      r.divide_by_zero = 1'b1;
    end else if (executes) begin
      r.write_enable = 1'b1;
      if (c.instruction_word[UNSIGNED_BIT]) begin
        r.quotient = a / b;
      end else begin
        mag_a = a[31] ? -a : a;
        mag_b = b[31] ? -b : b;
        q = mag_a / mag_b;
        r.quotient = (a[31] != b[31]) ? -q : q;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (n_errors < MAX_PRINTS) begin
      $display("MISMATCH result %0d: %s", n_results, msg);
    end
    n_errors++;
  endtask

  task automatic check_result(result_t got, result_t want);
    if (got.condition_outcome !== want.condition_outcome)
      report_mismatch($sformatf("condition_outcome got %0d want %0d",
                                got.condition_outcome, want.condition_outcome));
    if (got.is_divide !== want.is_divide)
      report_mismatch($sformatf("is_divide got %0b want %0b", got.is_divide, want.is_divide));
    if (got.write_enable !== want.write_enable)
      report_mismatch($sformatf("write_enable got %0b want %0b",
                                got.write_enable, want.write_enable));
    if (got.dest_register !== want.dest_register)
      report_mismatch($sformatf("dest_register got %0d want %0d",
                                got.dest_register, want.dest_register));
    if (got.quotient !== want.quotient)
      report_mismatch($sformatf("quotient got %h want %h", got.quotient, want.quotient));
    if (got.divide_by_zero !== want.divide_by_zero)
      report_mismatch($sformatf("divide_by_zero got %0b want %0b",
                                got.divide_by_zero, want.divide_by_zero));
  endtask

  function automatic logic [31:0] make_div_word(logic [3:0] cc, logic is_unsigned);
    logic [31:0] w;
    w = $urandom | DIV_PATTERN;
    w[31:28] = cc;
    w[UNSIGNED_BIT] = is_unsigned;
    return w;
  endfunction

  function automatic logic [31:0] pick_operand();
    unique case ($urandom_range(9))
      5, 6:    return $urandom_range(255);
      7: begin
        unique case ($urandom_range(4))
          0:       return 32'h0000_0000;
          1:       return 32'h0000_0001;
          2:       return 32'hFFFF_FFFF;
          3:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      8:       return -$urandom_range(255, 1);
      9:       return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(logic [31:0] w, logic [3:0] f, logic [31:0] a, logic [31:0] b,
                         bit drain_first = 1'b0, bit no_idle = 1'b0);
    pending_cmd_t p;
    p.c.instruction_word = w;
    p.c.nzcv_flags = f;
    p.c.dividend_value = a;
    p.c.divisor_value = b;
    p.drain_first = drain_first;
    p.no_idle = no_idle;
    pending_cmds.push_back(p);
  endtask

  always @(posedge clk) begin : drive_proc
    logic         launched;
    pending_cmd_t item;
    if (rst) begin
      start <= 1'b0;
    end else begin
      launched = start && !busy;
      if (launched) n_sent <= n_sent + 1;
      if (!start || launched) begin
        if (pending_cmds.size() == 0) begin
          start <= 1'b0;
        end else if (pending_cmds[0].drain_first && (n_sent + launched != n_results)) begin
          start <= 1'b0;
        end else if (!pending_cmds[0].no_idle && $urandom_range(99) < 19) begin
          start <= 1'b0;
        end else begin
          item = pending_cmds.pop_front();
          cmd <= item.c;
          start <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor_proc
    result_t want;
    if ((start && !busy) || done) cycles_idle <= 0;
    else cycles_idle <= cycles_idle + 1;
    if (cycles_idle >= STALL_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else if (!rst) begin
      if (start && !busy) begin
        want = predict_divide(cmd);
        expected_results.push_back(want);
        if (!want.is_divide) n_not_div++;
        else if (want.condition_outcome == OUTCOME_FAIL) n_cond_fail++;
        else if (want.divide_by_zero) n_div_zero++;
        else if (cmd.instruction_word[UNSIGNED_BIT]) n_exec_unsigned++;
        else n_exec_signed++;
      end
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with no pending transaction, quotient %h",
                                    result.quotient));
        end else begin
          check_result(result, expected_results.pop_front());
        end
        n_results <= n_results + 1;
      end
    end
  end

  initial begin : stimulus_proc
    logic [31:0] w;
    int          pos;
    int          kind;
    for (int cc = 0; cc < 16; cc++) begin
      add_cmd(make_div_word(4'(cc), cc[0]), 4'($urandom_range(15)), pick_operand(),
              $urandom_range(1000, 1));
    end
    add_cmd(make_div_word(CC_AL, 1'b0), 4'h0, 32'h8000_0000, 32'hFFFF_FFFF);
    add_cmd(make_div_word(CC_AL, 1'b1), 4'h0, 32'h8000_0000, 32'hFFFF_FFFF);
    add_cmd(32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF, 32'h0000_0001);
    add_cmd(make_div_word(CC_AL, 1'b0), 4'h5, 32'h1234_5678, 32'h0000_0000);
    add_cmd(make_div_word(CC_EQ, 1'b1), 4'h0, 32'h1234_5678, 32'h0000_0000);
    add_cmd(32'h0000_0000, 4'h0, 32'h0000_0000, 32'h0000_0000);
    add_cmd(make_div_word(CC_AL, 1'b0) & ~32'h0000_0010, 4'h0, 32'd100, 32'd7);
    add_cmd(make_div_word(CC_AL, 1'b0), 4'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_cmd(make_div_word(CC_NV, 1'b0), 4'h0, -32'sd7, 32'd2);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      kind = $urandom_range(99);
      if (kind < 75) begin
        w = make_div_word(4'($urandom_range(15)), 1'($urandom_range(1)));
      end else if (kind < 90) begin
        w = $urandom;
      end else begin
        w = make_div_word(4'($urandom_range(15)), 1'($urandom_range(1)));
        do pos = $urandom_range(31); while (!DIV_PATTERN[pos]);
        w[pos] = 1'b0;
      end
      add_cmd(w, 4'($urandom_range(15)), pick_operand(),
              ($urandom_range(99) < 5) ? 32'd0 : pick_operand(),
              (i % 450) == 449, (i >= 500) && (i < 800));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (n_sent != n_results) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    $display("Ran %0d transactions: %0d signed and %0d unsigned divides executed,",
             n_sent, n_exec_signed, n_exec_unsigned);
    $display("%0d zero-divisor faults, %0d failed conditions, %0d non-divide words",
             n_div_zero, n_cond_fail, n_not_div);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
